@@ rtl/spectrum_band_bar_levels_macros.svh @@
// Assertion macros for the band bar level block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SPECTRUM_BAND_BAR_LEVELS_MACROS_SVH
`define SPECTRUM_BAND_BAR_LEVELS_MACROS_SVH

// Condition holds at every edge outside reset.
`define SBBL_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SBBL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/sbbl_pkg.sv @@
// Shared types, constants and band tables for the band bar level block.
// No dependencies.
package sbbl_pkg;

    localparam int NUM_BANDS          = 20;
    localparam int BAND_W             = 5;
    localparam int BAR_W              = 7;
    localparam int MAG_W              = 25;
    localparam int SUM_W              = 32;
    localparam int MULT_W             = 18;
    localparam int PROD_W             = SUM_W + MULT_W;
    localparam int BIN_W              = 8;
    localparam int MULT_FRAC_BITS     = 16;
    localparam int MAG_FRAC_BITS_DEF  = 16;

    localparam logic [BIN_W-1:0]  LAST_BIN    = 8'd255;
    localparam logic [BAR_W-1:0]  BAR_MAX     = 7'd100;
    localparam logic [BAR_W-1:0]  DECAY_RESET = 7'd3;
    localparam logic [BAND_W-1:0] BAND_LIMIT  = 5'd20;

    typedef struct packed {
        logic              valid;
        logic [BAND_W-1:0] band;
        logic [SUM_W-1:0]  sum;
    } band_done_t;

    typedef struct packed {
        logic              valid;
        logic [BAND_W-1:0] band;
        logic [PROD_W-1:0] prod;
    } band_prod_t;

    // Index of the last bin that belongs to a band.
    function automatic logic [BIN_W-1:0] band_last_bin(input logic [BAND_W-1:0] band);
        logic [BIN_W-1:0] last;
        case (band)
            5'd0:    last = 8'd1;
            5'd1:    last = 8'd2;
            5'd2:    last = 8'd3;
            5'd3:    last = 8'd4;
            5'd4:    last = 8'd5;
            5'd5:    last = 8'd7;
            5'd6:    last = 8'd9;
            5'd7:    last = 8'd12;
            5'd8:    last = 8'd16;
            5'd9:    last = 8'd21;
            5'd10:   last = 8'd27;
            5'd11:   last = 8'd35;
            5'd12:   last = 8'd45;
            5'd13:   last = 8'd59;
            5'd14:   last = 8'd77;
            5'd15:   last = 8'd99;
            5'd16:   last = 8'd129;
            5'd17:   last = 8'd169;
            5'd18:   last = 8'd209;
            5'd19:   last = 8'd254;
            default: last = 8'd0;
        endcase
        return last;
    endfunction

    // Per-band scale, unsigned Q2.16.
    function automatic logic [MULT_W-1:0] band_mult(input logic [BAND_W-1:0] band);
        logic [MULT_W-1:0] mult;
        case (band)
            5'd0:    mult = 18'd51200;
            5'd1:    mult = 18'd76800;
            5'd2:    mult = 18'd102400;
            5'd3:    mult = 18'd128000;
            5'd4:    mult = 18'd153600;
            5'd5:    mult = 18'd89600;
            5'd6:    mult = 18'd102400;
            5'd7:    mult = 18'd76800;
            5'd8:    mult = 18'd64000;
            5'd9:    mult = 18'd56320;
            5'd10:   mult = 18'd51200;
            5'd11:   mult = 18'd41600;
            5'd12:   mult = 18'd35840;
            5'd13:   mult = 18'd27429;
            5'd14:   mult = 18'd22756;
            5'd15:   mult = 18'd19782;
            5'd16:   mult = 18'd15360;
            5'd17:   mult = 18'd12160;
            5'd18:   mult = 18'd12800;
            5'd19:   mult = 18'd11947;
            default: mult = 18'd0;
        endcase
        return mult;
    endfunction

endpackage

@@ rtl/spectrum_band_bar_levels.sv @@
// Top level of the spectrum band bar level block.
// Depends on sbbl_pkg, sbbl_accum, sbbl_scale, sbbl_bar and the macros header.
//
// Usage:
//   Input channel (in_valid/in_ready): one FFT magnitude bin per transfer, bins 0..255
//   of a frame in order; first_of_frame marks bin 0 and restarts the bin count.
//   Output channel (out_valid/out_ready): one transfer per completed band, carrying
//   band_index and the updated bar_level (0..100). Bins 0 and 255 produce nothing.
//   cfg_we/cfg_data write decay_step; write it only while idle.
//   A band result passes from the transfer of its last bin through the input register,
//   accumulator register, product register and result register before it is presented.
//   Throughput: one bin per cycle unless stalled; every stage is a single register step,
//   the 32x18 band multiply sits alone between the accumulator and product registers.
//   Reset: bars cleared to 0, bin count, band pointer and band sum cleared,
//   decay_step returns to 3; no clearing pass is needed.
//   Stall: while a result waits untaken, the whole pipeline holds and in_ready is
//   low; it drops in the same cycle that out_ready is low with a result pending.
`include "spectrum_band_bar_levels_macros.svh"

module spectrum_band_bar_levels #(
    parameter int MAG_FRAC_BITS = sbbl_pkg::MAG_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbbl_pkg::MAG_W-1:0]    bin_magnitude,
    input  logic                          first_of_frame,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sbbl_pkg::BAND_W-1:0]   band_index,
    output logic [sbbl_pkg::BAR_W-1:0]    bar_level,
    input  logic                          cfg_we,
    input  logic [sbbl_pkg::BAR_W-1:0]    cfg_data
);

    logic                 advance;
    sbbl_pkg::band_done_t done;
    sbbl_pkg::band_prod_t prod;

    // Pipeline moves whenever the result register is empty or being drained.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    sbbl_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (in_valid),
        .bin_magnitude  (bin_magnitude),
        .first_of_frame (first_of_frame),
        .done           (done)
    );

    sbbl_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .done    (done),
        .prod    (prod)
    );

    sbbl_bar #(
        .MAG_FRAC_BITS (MAG_FRAC_BITS)
    ) u_bar (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .prod       (prod),
        .out_valid  (out_valid),
        .band_index (band_index),
        .bar_level  (bar_level)
    );

    `SBBL_ASSERT_IMP(a_bar_range, out_valid, bar_level <= sbbl_pkg::BAR_MAX, "bar above max")
    `SBBL_ASSERT_IMP(a_band_range, out_valid, band_index < sbbl_pkg::BAND_LIMIT, "bad band index")
    `SBBL_ASSERT_IMP(a_stall_holds_input, out_valid && !out_ready, !in_ready, "input taken in stall")

endmodule

@@ rtl/sbbl_accum.sv @@
// Input register, bin counter and band accumulator.
// Depends on sbbl_pkg.
module sbbl_accum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [sbbl_pkg::MAG_W-1:0]        bin_magnitude,
    input  logic                              first_of_frame,
    output sbbl_pkg::band_done_t              done
);

    logic                              s0_valid_reg;
    logic [sbbl_pkg::MAG_W-1:0]        mag_reg;
    logic                              first_reg;

    logic [sbbl_pkg::BIN_W-1:0]        cnt_reg, cnt_next;
    logic [sbbl_pkg::BAND_W-1:0]       ptr_reg, ptr_next;
    logic [sbbl_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [sbbl_pkg::SUM_W-1:0]        sum_add;
    logic [sbbl_pkg::BIN_W-1:0]        idx;
    logic                              hit;

    logic                              done_valid_reg;
    logic [sbbl_pkg::BAND_W-1:0]       done_band_reg;
    logic [sbbl_pkg::SUM_W-1:0]        done_sum_reg;

    always_comb
    begin
        idx      = first_reg ? '0 : cnt_reg;
        cnt_next = idx + 8'd1;
        sum_add  = sum_reg + {{(sbbl_pkg::SUM_W-sbbl_pkg::MAG_W){1'b0}}, mag_reg};
        sum_next = sum_reg;
        ptr_next = ptr_reg;
        hit      = 1'b0;
        if (idx == '0)
        begin
            sum_next = '0;
            ptr_next = '0;
        end
        else if (idx != sbbl_pkg::LAST_BIN && ptr_reg < sbbl_pkg::BAND_LIMIT)
        begin
            if (idx == sbbl_pkg::band_last_bin(ptr_reg))
            begin
                hit      = 1'b1;
                sum_next = '0;
                ptr_next = ptr_reg + 5'd1;
            end
            else
            begin
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
            sum_reg        <= '0;
            done_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg   <= in_valid;
            done_valid_reg <= s0_valid_reg && hit;
            if (s0_valid_reg)
            begin
                cnt_reg <= cnt_next;
                ptr_reg <= ptr_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg       <= bin_magnitude;
            first_reg     <= first_of_frame;
            done_band_reg <= ptr_reg;
            done_sum_reg  <= sum_add;
        end
    end

    assign done.valid = done_valid_reg;
    assign done.band  = done_band_reg;
    assign done.sum   = done_sum_reg;

endmodule

@@ rtl/sbbl_scale.sv @@
// Band sum times per-band multiplier, registered product.
// Depends on sbbl_pkg.
module sbbl_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  sbbl_pkg::band_done_t done,
    output sbbl_pkg::band_prod_t prod
);

    logic                              prod_valid_reg;
    logic [sbbl_pkg::BAND_W-1:0]       prod_band_reg;
    logic [sbbl_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [sbbl_pkg::MULT_W-1:0]       mult;

    always_comb
    begin
        mult      = sbbl_pkg::band_mult(done.band);
        prod_next = done.sum * mult;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prod_valid_reg <= done.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_band_reg <= done.band;
            prod_reg      <= prod_next;
        end
    end

    assign prod.valid = prod_valid_reg;
    assign prod.band  = prod_band_reg;
    assign prod.prod  = prod_reg;

endmodule

@@ rtl/sbbl_bar.sv @@
// Target clamp, bar store with decay/smoothing, decay register and result register.
// Depends on sbbl_pkg.
module sbbl_bar #(
    parameter int MAG_FRAC_BITS = sbbl_pkg::MAG_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          cfg_we,
    input  logic [sbbl_pkg::BAR_W-1:0]    cfg_data,
    input  sbbl_pkg::band_prod_t          prod,
    output logic                          out_valid,
    output logic [sbbl_pkg::BAND_W-1:0]   band_index,
    output logic [sbbl_pkg::BAR_W-1:0]    bar_level
);

    localparam int SHIFT   = sbbl_pkg::MULT_FRAC_BITS + MAG_FRAC_BITS;
    localparam int WHOLE_W = sbbl_pkg::PROD_W - SHIFT;

    logic [sbbl_pkg::BAR_W-1:0]   bar_reg [sbbl_pkg::NUM_BANDS];
    logic [sbbl_pkg::BAR_W-1:0]   decay_reg;
    logic                         out_valid_reg;
    logic [sbbl_pkg::BAND_W-1:0]  band_reg;
    logic [sbbl_pkg::BAR_W-1:0]   level_reg;

    logic [WHOLE_W-1:0]           whole;
    logic [sbbl_pkg::BAR_W-1:0]   target;
    logic [sbbl_pkg::BAR_W-1:0]   bar_old;
    logic [sbbl_pkg::BAR_W:0]     mean_sum;
    logic [sbbl_pkg::BAR_W-1:0]   bar_next;

    always_comb
    begin
        whole    = prod.prod[sbbl_pkg::PROD_W-1:SHIFT];
        target   = (whole > WHOLE_W'(sbbl_pkg::BAR_MAX)) ? sbbl_pkg::BAR_MAX
                                                         : whole[sbbl_pkg::BAR_W-1:0];
        bar_old  = bar_reg[prod.band];
        mean_sum = {1'b0, bar_old} + {1'b0, target};
        if (target < bar_old)
            bar_next = (bar_old > decay_reg) ? bar_old - decay_reg : '0;
        else
            bar_next = mean_sum[sbbl_pkg::BAR_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbbl_pkg::NUM_BANDS; i++)
                bar_reg[i] <= '0;
            decay_reg     <= sbbl_pkg::DECAY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                decay_reg <= cfg_data;
            if (advance)
            begin
                out_valid_reg <= prod.valid;
                if (prod.valid)
                    bar_reg[prod.band] <= bar_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            band_reg  <= prod.band;
            level_reg <= bar_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign band_index = band_reg;
    assign bar_level  = level_reg;

endmodule
